// File: src/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on clk_i, off while rst_ni is low.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Two signal expressions never high at once.
`define ASSERT_EXCL(label, a, b, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !((a) && (b))) \
    else $error(msg);

`endif

// File: src/lgs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lgs_pkg;

  localparam int GridRows = 32;
  localparam int GridCols = 32;
  localparam int RowIdxW  = $clog2(GridRows);

  localparam int InFieldW  = 32;
  localparam int IdxFieldW = 5;

  // B3/S23
  localparam int BirthCount   = 3;
  localparam int SurviveCount = 2;

  typedef logic [GridCols-1:0] row_t;
  typedef logic [RowIdxW-1:0]  row_idx_t;

  // 3x3 window around one cell: bit 0 left, bit 1 center, bit 2 right
  typedef struct packed {
    logic [2:0] up;
    logic [2:0] mid;
    logic [2:0] dn;
  } nbhd_t;

  typedef enum logic {
    ST_LOAD,
    ST_EMIT
  } state_e;

endpackage

`default_nettype wire

// File: src/life_generation_step_torus.sv
// Flow: after the last input row is taken the state moves to emit; from there each
//   next-generation row goes through the output register. A grid loads one row per cycle
//   while in_valid_i is high, then emits one row per cycle unless held by out_stall_i.
// Reset: state, row counter and output valid clear at once; the grid rows need no reset
//   and are fully rewritten before every generation.
`timescale 1ns / 1ps
`default_nettype none

module life_generation_step_torus (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input rows
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] row_cells_i,
  // next-generation rows
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] next_row_cells_o,
  output logic [4:0]  out_row_index_o,
  output logic        last_row_o
);

  `include "assert_macros.svh"

  localparam lgs_pkg::row_idx_t LastIdx = lgs_pkg::RowIdxW'(lgs_pkg::GridRows - 1);

  lgs_pkg::state_e   state_q, state_d;
  lgs_pkg::row_idx_t cnt_q, cnt_d;

  // Grid held as a row ring. Load shifts rows in at the top slot, so slot 0
  // ends up with row 0. During emit the ring rotates by one per row, so the
  // current row always sits in slot 0, the row below in slot 1 and the row
  // above in the top slot (vertical wrap for free).
  lgs_pkg::row_t grid_q [lgs_pkg::GridRows];
  lgs_pkg::row_t grid_d [lgs_pkg::GridRows];

  // output register
  logic              out_valid_q, out_valid_d;
  lgs_pkg::row_t     out_row_q;
  lgs_pkg::row_idx_t out_idx_q;
  logic              out_last_q;

  logic          in_xact;
  logic          out_xact;
  logic          out_load;
  logic          cnt_last;
  lgs_pkg::row_t next_row;

  assign in_xact  = in_valid_i && !in_stall_o;
  assign out_xact = out_valid_q && !out_stall_i;
  assign cnt_last = (cnt_q == LastIdx);

  // lanes: one cell per column, merged into one row
  lgs_gen_row u_gen (
    .up_i   (grid_q[lgs_pkg::GridRows-1]),
    .mid_i  (grid_q[0]),
    .dn_i   (grid_q[1]),
    .next_o (next_row)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      lgs_pkg::ST_LOAD: begin
        if (in_xact && cnt_last) state_d = lgs_pkg::ST_EMIT;
      end
      lgs_pkg::ST_EMIT: begin
        if (out_load && cnt_last) state_d = lgs_pkg::ST_LOAD;
      end
      default: state_d = lgs_pkg::ST_LOAD;
    endcase
  end

  // state outputs
  always_comb begin
    in_stall_o = 1'b1;
    out_load   = 1'b0;
    unique case (state_q)
      lgs_pkg::ST_LOAD: begin
        in_stall_o = 1'b0;
      end
      lgs_pkg::ST_EMIT: begin
        // room in the output register: empty, or being drained this cycle
        out_load = !out_valid_q || !out_stall_i;
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

  // row counter: rows loaded, then rows emitted
  always_comb begin
    cnt_d = cnt_q;
    if (in_xact || out_load) begin
      cnt_d = cnt_last ? '0 : cnt_q + lgs_pkg::RowIdxW'(1);
    end
  end

  // ring shift on load, rotate on emit
  always_comb begin
    grid_d = grid_q;
    if (in_xact) begin
      for (int k = 0; k < lgs_pkg::GridRows - 1; k++) grid_d[k] = grid_q[k+1];
      grid_d[lgs_pkg::GridRows-1] = lgs_pkg::row_t'(row_cells_i);
    end else if (out_load) begin
      for (int k = 0; k < lgs_pkg::GridRows - 1; k++) grid_d[k] = grid_q[k+1];
      grid_d[lgs_pkg::GridRows-1] = grid_q[0];
    end
  end

  always_comb begin
    priority if (out_load) out_valid_d = 1'b1;
    else if (out_xact)     out_valid_d = 1'b0;
    else                   out_valid_d = out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lgs_pkg::ST_LOAD;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    grid_q <= grid_d;
    if (out_load) begin
      out_row_q  <= next_row;
      out_idx_q  <= cnt_q;
      out_last_q <= cnt_last;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign next_row_cells_o = lgs_pkg::InFieldW'(out_row_q);
  assign out_row_index_o  = lgs_pkg::IdxFieldW'(out_idx_q);
  assign last_row_o       = out_last_q;

  // ---------------------------------------------------------------------------
  // checks

  // the last marker rides only on the bottom row
  `ASSERT_CLK(a_last_idx, (out_valid_o && last_row_o) |-> (out_idx_q == LastIdx), "last_row on wrong row")

  // loading and emitting never overlap
  `ASSERT_EXCL(a_load_emit_excl, !in_stall_o, out_load, "row taken while emitting")

  // once the last row leaves while loading, nothing follows until a new grid is loaded
  `ASSERT_CLK(a_drain_after_last,
              (out_xact && last_row_o && state_q == lgs_pkg::ST_LOAD) |=> !out_valid_o,
              "result after last row")

endmodule

`default_nettype wire

// File: src/lgs_cell_lane.sv
`timescale 1ns / 1ps
`default_nettype none

module lgs_cell_lane (
  input  lgs_pkg::nbhd_t nbhd_i,
  output logic           alive_o
);

  logic [3:0] cnt;

  always_comb begin
    cnt = 4'(nbhd_i.up[0]) + 4'(nbhd_i.up[1]) + 4'(nbhd_i.up[2])
        + 4'(nbhd_i.mid[0]) + 4'(nbhd_i.mid[2])
        + 4'(nbhd_i.dn[0]) + 4'(nbhd_i.dn[1]) + 4'(nbhd_i.dn[2]);
    alive_o = (cnt == 4'(lgs_pkg::BirthCount))
           || (nbhd_i.mid[1] && (cnt == 4'(lgs_pkg::SurviveCount)));
  end

endmodule

`default_nettype wire

// File: src/lgs_gen_row.sv
`timescale 1ns / 1ps
`default_nettype none

module lgs_gen_row (
  input  lgs_pkg::row_t up_i,
  input  lgs_pkg::row_t mid_i,
  input  lgs_pkg::row_t dn_i,
  output lgs_pkg::row_t next_o
);

  // one lane per column, wrap on the column axis
  for (genvar j = 0; j < lgs_pkg::GridCols; j++) begin : g_lane
    localparam int Lft = (j + lgs_pkg::GridCols - 1) % lgs_pkg::GridCols;
    localparam int Rgt = (j + 1) % lgs_pkg::GridCols;

    lgs_pkg::nbhd_t nb;

    assign nb.up  = {up_i[Rgt],  up_i[j],  up_i[Lft]};
    assign nb.mid = {mid_i[Rgt], mid_i[j], mid_i[Lft]};
    assign nb.dn  = {dn_i[Rgt],  dn_i[j],  dn_i[Lft]};

    lgs_cell_lane u_lane (
      .nbhd_i  (nb),
      .alive_o (next_o[j])
    );
  end

endmodule

`default_nettype wire

// File: dv/lgs_generation_checker.sv
`timescale 1ns / 1ps

// Watches both channels of the life step block, keeps its own copy of the
// grid being loaded, predicts each next generation and compares every row.
module lgs_generation_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [31:0] row_cells_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [31:0] next_row_cells_i,
  input  logic [4:0]  out_row_index_i,
  input  logic        last_row_i,
  output int          mismatch_count_o,
  output int          pending_rows_o,
  output int          rows_checked_o
);

  typedef struct packed {
    lgs_pkg::row_t     cells;
    lgs_pkg::row_idx_t idx;
    logic              last;
  } gen_row_t;

  lgs_pkg::row_t grid_cells [lgs_pkg::GridRows];
  int            rows_loaded;
  gen_row_t      next_gen_q [$];
  gen_row_t      want;
  int            mismatches;
  int            pending;
  int            checked;

  assign mismatch_count_o = mismatches;
  assign pending_rows_o   = pending;
  assign rows_checked_o   = checked;

  // B3/S23 on a torus: every neighbour index wraps on both axes
  task automatic predict_generation();
    gen_row_t nxt;
    int       cnt;
    logic     alive;
    for (int i = 0; i < lgs_pkg::GridRows; i++) begin
      nxt.cells = '0;
      for (int j = 0; j < lgs_pkg::GridCols; j++) begin
        cnt   = 0;
        alive = grid_cells[i][j];
        for (int dr = -1; dr <= 1; dr++) begin
          for (int dc = -1; dc <= 1; dc++) begin
            if (dr != 0 || dc != 0) begin
              cnt += grid_cells[(i + dr + lgs_pkg::GridRows) % lgs_pkg::GridRows]
                               [(j + dc + lgs_pkg::GridCols) % lgs_pkg::GridCols];
            end
          end
        end
        nxt.cells[j] = (cnt == lgs_pkg::BirthCount)
                    || (alive && cnt == lgs_pkg::SurviveCount);
      end
      nxt.idx  = lgs_pkg::row_idx_t'(i);
      nxt.last = (i == lgs_pkg::GridRows - 1);
      next_gen_q.push_back(nxt);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_loaded = 0;
      next_gen_q.delete();
      mismatches  = 0;
      pending     = 0;
      checked     = 0;
    end else begin
      if (in_valid_i && !in_stall_i) begin
        grid_cells[rows_loaded] = row_cells_i[lgs_pkg::GridCols-1:0];
        rows_loaded++;
        if (rows_loaded == lgs_pkg::GridRows) begin
          predict_generation();
          rows_loaded = 0;
        end
      end
      if (out_valid_i && !out_stall_i) begin
        if (next_gen_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("unexpected row: cells %h idx %0d last %b",
                     next_row_cells_i, out_row_index_i, last_row_i);
          end
        end else begin
          want = next_gen_q.pop_front();
          checked++;
          if (next_row_cells_i !== want.cells || out_row_index_i !== want.idx ||
              last_row_i !== want.last) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("row mismatch: expected cells %h idx %0d last %b,",
                       want.cells, want.idx, want.last,
                       " got cells %h idx %0d last %b",
                       next_row_cells_i, out_row_index_i, last_row_i);
            end
          end
        end
      end
      pending = next_gen_q.size();
    end
  end

endmodule

// File: dv/life_generation_step_torus_tb.sv
`timescale 1ns / 1ps

// Stimulus and verdict for the toroidal life step. The checker beside the
// block does all prediction; this module only feeds grids, stalls the
// output side and decides pass or fail.
module life_generation_step_torus_tb;

  localparam int CycleLimit = 200000;
  localparam int RandGrids  = 8;
  localparam int LongHold   = 400;   // output held off long enough to back up the input

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [31:0] row_cells_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [31:0] next_row_cells_o;
  logic [4:0]  out_row_index_o;
  logic        last_row_o;

  int mismatch_count;
  int pending_rows;
  int rows_checked;
  int rows_sent;
  int cycles;

  // knobs shared between the sender and the receiver process
  logic tx_quiet;
  logic rx_quiet;
  logic long_hold_req;
  logic long_hold_done;

  life_generation_step_torus uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .row_cells_i      (row_cells_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .next_row_cells_o (next_row_cells_o),
    .out_row_index_o  (out_row_index_o),
    .last_row_o       (last_row_o)
  );

  lgs_generation_checker checker_i (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_i       (in_stall_o),
    .row_cells_i      (row_cells_i),
    .out_valid_i      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .next_row_cells_i (next_row_cells_o),
    .out_row_index_i  (out_row_index_o),
    .last_row_i       (last_row_o),
    .mismatch_count_o (mismatch_count),
    .pending_rows_o   (pending_rows),
    .rows_checked_o   (rows_checked)
  );

  // 12 ns clock
  initial clk_i = 1'b0;
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Watchdog: a hung handshake or a missing row ends the run here.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles, %0d rows still expected", cycles, pending_rows);
      $display("Some tests failed");
      $finish;
    end
  end

  // Output side. Each decision holds out_stall_i for a run of falling edges:
  // random stall bursts, free stretches between them, one long hold
  // when the sender asks for it, and no stalls at all once rx_quiet is set.
  initial begin : rx_drive
    logic lvl;
    int   len;
    out_stall_i    = 1'b0;
    long_hold_done = 1'b0;
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      if (long_hold_req && !long_hold_done) begin
        lvl            = 1'b1;
        len            = LongHold;
        long_hold_done = 1'b1;
      end else if (!rx_quiet && $urandom_range(0, 3) == 0) begin
        lvl = 1'b1;
        len = $urandom_range(1, 9);
      end else begin
        lvl = 1'b0;
        len = $urandom_range(1, 12);
      end
      out_stall_i <= lvl;
      repeat (len - 1) @(negedge clk_i);
    end
  end

  // One row transaction. Entered and left on a falling edge; valid stays high
  // from one row to the next unless an idle burst is inserted in between.
  task automatic send_row(input logic [31:0] cells);
    if (!tx_quiet && $urandom_range(0, 2) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    row_cells_i <= cells;
    do @(posedge clk_i); while (in_stall_o);
    rows_sent++;
    @(negedge clk_i);
  endtask

  // Stop offering rows until every predicted row has come out.
  task automatic drain_outputs();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (pending_rows != 0) @(negedge clk_i);
  endtask

  // Random row whose live density depends on the grid's mode.
  function automatic logic [31:0] random_row(input int mode);
    logic [31:0] a;
    logic [31:0] b;
    a = $urandom();
    b = $urandom();
    case (mode)
      0:       return a & b & $urandom();          // sparse: mostly deaths and births
      1:       return a & b;                       // about a quarter alive
      2:       return a;                           // half alive
      3:       return a | b;                       // crowded: overpopulation
      default: begin
        case ($urandom_range(0, 5))
          0:       return '0;
          1:       return '1;
          2:       return 32'h1 << $urandom_range(0, 31);
          default: return a & b;
        endcase
      end
    endcase
  endfunction

  lgs_pkg::row_t seed_grid [lgs_pkg::GridRows];
  int            mode;

  initial begin : stimulus
    cycles         = 0;
    rows_sent      = 0;
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    row_cells_i    = '0;
    tx_quiet       = 1'b0;
    rx_quiet       = 1'b0;
    long_hold_req  = 1'b0;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed grid: known shapes, several placed across the wrap seams.
    for (int i = 0; i < lgs_pkg::GridRows; i++) seed_grid[i] = '0;
    seed_grid[0]  = 32'hFFFF_FFFF;   // full row next to the bottom row via row wrap
    seed_grid[3]  = 32'h0000_000E;   // blinker: births above and below, ends die
    seed_grid[5]  = 32'h8000_0001;   // 2x2 block split by the column seam
    seed_grid[6]  = 32'h8000_0001;
    seed_grid[8]  = 32'h0001_0000;   // lone cell dies of isolation
    seed_grid[10] = 32'h0000_0040;   // glider
    seed_grid[11] = 32'h0000_0080;
    seed_grid[12] = 32'h0000_01C0;
    seed_grid[14] = 32'hAAAA_AAAA;   // checkerboard rows: overcrowding
    seed_grid[15] = 32'h5555_5555;
    seed_grid[18] = 32'h0F0F_0000;
    seed_grid[24] = 32'h8000_0000;
    seed_grid[26] = 32'h8000_0003;   // three in a row across the column seam
    seed_grid[31] = 32'h0000_0700;   // sits against the full top row
    for (int i = 0; i < lgs_pkg::GridRows; i++) send_row(seed_grid[i]);

    // Pause with nothing offered until the first generation is out.
    drain_outputs();

    for (int g = 0; g < RandGrids; g++) begin
      mode = (g < 5) ? g : $urandom_range(0, 4);
      // Long output hold while this grid loads: the block completes the grid,
      // cannot emit, and must stall the next grid's rows.
      if (g == 2) long_hold_req = 1'b1;
      // Last part of the run with no idling on either side.
      if (g == RandGrids - 2) begin
        tx_quiet = 1'b1;
        rx_quiet = 1'b1;
      end
      for (int i = 0; i < lgs_pkg::GridRows; i++) send_row(random_row(mode));
      if (g == 4) drain_outputs();
    end
    in_valid_i <= 1'b0;

    // Wait out every predicted row, then idle on to catch stray outputs.
    while (pending_rows != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);

    $display("Loaded %0d rows as %0d grids (seam shapes, oscillators, random densities)",
             rows_sent, rows_sent / lgs_pkg::GridRows);
    $display("Checked %0d next-generation rows under random stalls and one long output hold",
             rows_checked);
    if (mismatch_count == 0 && pending_rows == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
